>>> rtl/pcfl_pkg.sv
// Package for the per-core chunk free-list cache.
// Holds field widths, command, status and register codes, and reset values.
// No dependencies.
package pcfl_pkg;

  localparam int ADDR_W   = 48;
  localparam int LIMIT_W  = 41;
  localparam int LOG2_W   = 6;
  localparam int CORE_W   = 2;
  localparam int CFG_IDX_W = 3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_LOCAL    = 3'd0,
    ST_STOLEN   = 3'd1,
    ST_SYSTEM   = 3'd2,
    ST_KEPT     = 3'd3,
    ST_RELEASED = 3'd4
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_LIMIT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEAL_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CACHE_DISABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_KEEP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_KEEP      = 3'd4;

  localparam logic [LIMIT_W-1:0] KEEP_LIMIT_RST    = 41'd1073741824;
  localparam logic [LIMIT_W-1:0] STEAL_LIMIT_RST   = 41'd107374182;
  localparam logic [LOG2_W-1:0]  MIN_KEEP_RST      = 6'd12;
  localparam logic [LOG2_W-1:0]  MAX_KEEP_RST      = 6'd26;

endpackage

>>> rtl/pcfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the chunk stacks and the stack fill counts. No dependencies.
module pcfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/per_core_chunk_free_list_cache.sv
// Per-core chunk free-list cache: LIFO stacks of freed chunk addresses, one per core and
// size class, with a running reserved-byte total. Depends on pcfl_pkg and pcfl_ram.
//
// One request at a time. After reset a clearing pass writes every fill count to zero, one
// per cycle, over 2**(ceil(log2(NUM_CORES)) + ceil(log2(NUM_CLASSES))) addresses (256
// at the defaults); in_ready stays low meanwhile. A request passes S_LOOKUP, then S_FINISH
// if rejected, else S_COUNT (plus S_POP on a hit) and S_FINISH; a steal revisits S_LOOKUP
// and S_COUNT for each further core, as the fill-count RAM read is registered. All reserve
// arithmetic goes through one 42-bit add/subtract unit. The next request is taken while a
// finished response waits in the output register.
module per_core_chunk_free_list_cache #(
  parameter int NUM_CORES   = 4,
  parameter int NUM_CLASSES = 64,
  parameter int STACK_DEPTH = 16,
  parameter int ADDR_BITS   = 48
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [pcfl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcfl_pkg::LIMIT_W-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              cmd,
  input  logic [pcfl_pkg::CORE_W-1:0]       requester_core,
  input  logic [pcfl_pkg::LOG2_W-1:0]       size_log2,
  input  logic [pcfl_pkg::ADDR_W-1:0]       chunk_addr,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        status,
  output logic [pcfl_pkg::ADDR_W-1:0]       granted_addr,
  output logic [pcfl_pkg::CORE_W-1:0]       owner_core
);
  import pcfl_pkg::*;

  localparam int CW   = NUM_CORES > 1 ? $clog2(NUM_CORES) : 1;
  localparam int KW   = NUM_CLASSES > 1 ? $clog2(NUM_CLASSES) : 1;
  localparam int SW   = STACK_DEPTH > 1 ? $clog2(STACK_DEPTH) : 1;
  localparam int CNTW = $clog2(STACK_DEPTH + 1);
  localparam int MW   = ADDR_BITS < ADDR_W ? ADDR_BITS : ADDR_W;
  localparam int CAW  = CW + KW;
  localparam int SAW  = CW + KW + SW;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LOOKUP, S_COUNT, S_POP, S_FINISH
  } state_t;

  state_t state;

  logic [LIMIT_W-1:0] keep_limit;
  logic [LIMIT_W-1:0] steal_limit;
  logic               cache_disable;
  logic [LOG2_W-1:0]  min_keep_log2;
  logic [LOG2_W-1:0]  max_keep_log2;
  logic [LIMIT_W-1:0] reserved_total;

  logic               cmd_r;
  logic [CORE_W-1:0]  req_core_r;
  logic [LOG2_W-1:0]  cls_r;
  logic [MW-1:0]      addr_r;
  logic               usable_r;
  logic               keep_r;
  logic [CW-1:0]      cur_core;
  logic [CW-1:0]      home_core;
  logic               scanning;
  logic [CAW-1:0]     clr_addr;

  status_t            res_status;
  logic [ADDR_W-1:0]  res_addr;
  logic [CORE_W-1:0]  res_owner;

  logic [7:0]         in_core_ext;
  logic [7:0]         cur_core_ext;
  logic [CW-1:0]      next_core;
  logic [KW-1:0]      cls_idx;
  logic               big;
  logic [LIMIT_W-1:0] size_bytes;

  logic [LIMIT_W:0]   au_a;
  logic [LIMIT_W:0]   au_b;
  logic               au_sub;
  logic [LIMIT_W:0]   au_sum;

  logic               cnt_we;
  logic [CAW-1:0]     cnt_waddr;
  logic [CNTW-1:0]    cnt_wdata;
  logic [CAW-1:0]     cnt_raddr;
  logic [CNTW-1:0]    cnt_rdata;
  logic [CNTW-1:0]    cnt_inc;
  logic [CNTW-1:0]    cnt_dec;
  logic               stk_we;
  logic [SAW-1:0]     stk_waddr;
  logic [SAW-1:0]     stk_raddr;
  logic [MW-1:0]      stk_rdata;
  logic               keep_ok;
  logic               pop_ok;

  assign in_ready     = (state == S_IDLE);
  assign in_core_ext  = 8'(requester_core);
  assign cur_core_ext = 8'(cur_core);
  assign next_core    = (cur_core == CW'(NUM_CORES - 1)) ? '0 : cur_core + 1'b1;
  assign cls_idx      = cls_r[KW-1:0];
  assign big          = (cls_r >= LOG2_W'(LIMIT_W));
  assign size_bytes   = big ? '0 : (LIMIT_W'(1) << cls_r);

  // shared reserve add/subtract unit
  always_comb begin
    if (state == S_COUNT && (cmd_r == CMD_FREE || cnt_rdata != '0)) begin
      au_a   = {1'b0, reserved_total};
      au_b   = {1'b0, size_bytes};
      au_sub = (cmd_r == CMD_ALLOC);
    end else begin
      au_a   = {1'b0, steal_limit};
      au_b   = {1'b0, reserved_total};
      au_sub = 1'b1;
    end
    au_sum = au_a + (au_b ^ {(LIMIT_W + 1){au_sub}}) + (LIMIT_W + 1)'(au_sub);
  end

  assign cnt_inc = cnt_rdata + 1'b1;
  assign cnt_dec = cnt_rdata - 1'b1;
  assign keep_ok = !big && (au_sum <= {1'b0, keep_limit}) &&
                   (cnt_rdata < CNTW'(STACK_DEPTH));
  assign pop_ok  = (cnt_rdata != '0);

  always_comb begin
    cnt_raddr = {cur_core, cls_idx};
    stk_waddr = {cur_core, cls_idx, cnt_rdata[SW-1:0]};
    stk_raddr = {cur_core, cls_idx, cnt_dec[SW-1:0]};
    stk_we    = (state == S_COUNT) && (cmd_r == CMD_FREE) && keep_ok;
    if (state == S_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_addr;
      cnt_wdata = '0;
    end else begin
      cnt_we    = (state == S_COUNT) && ((cmd_r == CMD_FREE) ? keep_ok : pop_ok);
      cnt_waddr = {cur_core, cls_idx};
      cnt_wdata = (cmd_r == CMD_FREE) ? cnt_inc : cnt_dec;
    end
  end

  pcfl_ram #(
    .WIDTH (CNTW),
    .DEPTH (NUM_CORES << KW)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  pcfl_ram #(
    .WIDTH (MW),
    .DEPTH (NUM_CORES << (KW + SW))
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (addr_r),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_addr       <= '0;
      out_valid      <= 1'b0;
      scanning       <= 1'b0;
      reserved_total <= '0;
      keep_limit     <= KEEP_LIMIT_RST;
      steal_limit    <= STEAL_LIMIT_RST;
      cache_disable  <= 1'b0;
      min_keep_log2  <= MIN_KEEP_RST;
      max_keep_log2  <= MAX_KEEP_RST;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_KEEP_LIMIT:    keep_limit    <= cfg_data;
          CFG_STEAL_LIMIT:   steal_limit   <= cfg_data;
          CFG_CACHE_DISABLE: cache_disable <= cfg_data[0];
          CFG_MIN_KEEP:      min_keep_log2 <= cfg_data[LOG2_W-1:0];
          CFG_MAX_KEEP:      max_keep_log2 <= cfg_data[LOG2_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_r      <= cmd;
            req_core_r <= requester_core;
            cls_r      <= size_log2;
            addr_r     <= chunk_addr[MW-1:0];
            usable_r   <= (7'(requester_core) < 7'(NUM_CORES)) &&
                          (7'(size_log2) < 7'(NUM_CLASSES)) && !cache_disable;
            keep_r     <= (size_log2 > min_keep_log2) && (size_log2 < max_keep_log2);
            cur_core   <= in_core_ext[CW-1:0];
            home_core  <= in_core_ext[CW-1:0];
            scanning   <= 1'b0;
            state      <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          res_owner <= req_core_r;
          if (!usable_r || (cmd_r == CMD_FREE && !keep_r)) begin
            res_status <= (cmd_r == CMD_FREE) ? ST_RELEASED : ST_SYSTEM;
            res_addr   <= (cmd_r == CMD_FREE) ? ADDR_W'(addr_r) : '0;
            state      <= S_FINISH;
          end else begin
            state <= S_COUNT;
          end
        end
        S_COUNT: begin
          if (cmd_r == CMD_FREE) begin
            if (keep_ok) begin
              reserved_total <= au_sum[LIMIT_W-1:0];
              res_status     <= ST_KEPT;
              res_addr       <= '0;
            end else begin
              res_status <= ST_RELEASED;
              res_addr   <= ADDR_W'(addr_r);
            end
            state <= S_FINISH;
          end else if (pop_ok) begin
            reserved_total <= (big || au_sum[LIMIT_W]) ? '0 : au_sum[LIMIT_W-1:0];
            state          <= S_POP;
          end else if (scanning ? (next_core == home_core)
                                : (!au_sum[LIMIT_W] || next_core == home_core)) begin
            res_status <= ST_SYSTEM;
            res_addr   <= '0;
            state      <= S_FINISH;
          end else begin
            scanning <= 1'b1;
            cur_core <= next_core;
            state    <= S_LOOKUP;
          end
        end
        S_POP: begin
          res_status <= scanning ? ST_STOLEN : ST_LOCAL;
          res_addr   <= ADDR_W'(stk_rdata);
          res_owner  <= cur_core_ext[CORE_W-1:0];
          state      <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            granted_addr <= res_addr;
            owner_core   <= res_owner;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_kept_no_addr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_KEPT) |-> granted_addr == '0)
    else $error("kept response carries an address");

  a_steal_other_core: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP && scanning) |-> cur_core != home_core)
    else $error("steal pops from the requesting core");

  a_accept_lookup: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_LOOKUP)
    else $error("accepted request did not start lookup");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_COUNT && cmd_r == CMD_ALLOC && cnt_we) |-> cnt_rdata != '0)
    else $error("pop from empty stack");

endmodule

>>> dv/per_core_chunk_free_list_cache_tb.sv
// Testbench for per_core_chunk_free_list_cache: directed and random alloc/free traffic,
// checked against an in-bench model of the per-core stacks and the reserved-byte total.
// Depends on pcfl_pkg and the RTL of the cache.
module per_core_chunk_free_list_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pcfl_pkg::*;

  localparam int CORES       = 4;
  localparam int CLASSES     = 64;
  localparam int DEPTH       = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    status_t           st;
    logic [ADDR_W-1:0] addr;
    logic [CORE_W-1:0] owner;
  } grant_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LIMIT_W-1:0]   cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 req_cmd = CMD_ALLOC;
  logic [CORE_W-1:0]    req_core = '0;
  logic [LOG2_W-1:0]    req_log2 = '0;
  logic [ADDR_W-1:0]    req_addr = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [2:0]           status;
  logic [ADDR_W-1:0]    granted_addr;
  logic [CORE_W-1:0]    owner_core;

  logic [ADDR_W-1:0] chunk_stack [CORES][CLASSES][DEPTH];
  int                fill_count [CORES][CLASSES];
  logic [63:0]       held_bytes = '0;
  logic [63:0]       lim_reserve = 64'(KEEP_LIMIT_RST);
  logic [63:0]       lim_steal = 64'(STEAL_LIMIT_RST);
  logic              cache_off = 1'b0;
  int                keep_lo = int'(MIN_KEEP_RST);
  int                keep_hi = int'(MAX_KEEP_RST);

  grant_t grant_q[$];
  int     errors = 0;
  int     cycle_cnt = 0;
  int     hold_cycles = 0;
  int     rx_mode = 0;
  int     rx_tick = 0;
  bit     gaps_on = 1'b0;
  int     burst_left = 0;

  per_core_chunk_free_list_cache uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (req_cmd),
    .requester_core(req_core),
    .size_log2     (req_log2),
    .chunk_addr    (req_addr),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .granted_addr  (granted_addr),
    .owner_core    (owner_core)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("per_core_chunk_free_list_cache_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      case (rx_mode)
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ((rx_tick % 8) >= 3);
        3: out_ready <= ($urandom_range(0, 1) != 0);
        default: out_ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    grant_t e;
    if (!rst && out_valid && out_ready) begin
      if (grant_q.size() == 0) begin
        $display("%0t: result with none pending: status %0d addr %h owner %0d",
                 $time, status, granted_addr, owner_core);
        errors++;
      end else begin
        e = grant_q.pop_front();
        if (status !== e.st) begin
          $display("%0t: status expected %0d got %0d", $time, e.st, status);
          errors++;
        end
        if (granted_addr !== e.addr) begin
          $display("%0t: granted_addr expected %h got %h", $time, e.addr, granted_addr);
          errors++;
        end
        if (owner_core !== e.owner) begin
          $display("%0t: owner_core expected %0d got %0d", $time, e.owner, owner_core);
          errors++;
        end
      end
    end
  end

  function automatic logic [ADDR_W-1:0] take_chunk(int core, int cls);
    logic [63:0] sz;
    sz = 64'd1 << cls;
    fill_count[core][cls]--;
    held_bytes = (held_bytes > sz) ? held_bytes - sz : 64'd0;
    return chunk_stack[core][cls][fill_count[core][cls]];
  endfunction

  function automatic grant_t predict_grant(logic c, int core, int cls, logic [ADDR_W-1:0] a);
    grant_t      g;
    logic [63:0] nxt;
    int          o;
    int          k;
    g.st = ST_SYSTEM;
    g.addr = '0;
    g.owner = CORE_W'(core);
    if (c == CMD_ALLOC) begin
      if (!cache_off) begin
        if (fill_count[core][cls] != 0) begin
          g.addr = take_chunk(core, cls);
          g.st = ST_LOCAL;
        end else if (held_bytes > lim_steal) begin
          for (k = 1; k < CORES; k++) begin
            o = (core + k) % CORES;
            if (g.st == ST_SYSTEM && fill_count[o][cls] != 0) begin
              g.addr = take_chunk(o, cls);
              g.st = ST_STOLEN;
              g.owner = CORE_W'(o);
            end
          end
        end
      end
    end else begin
      g.st = ST_RELEASED;
      g.addr = a;
      nxt = held_bytes + (64'd1 << cls);
      if (!cache_off && cls > keep_lo && cls < keep_hi && nxt <= lim_reserve &&
          fill_count[core][cls] < DEPTH) begin
        chunk_stack[core][cls][fill_count[core][cls]] = a;
        fill_count[core][cls]++;
        held_bytes = nxt;
        g.st = ST_KEPT;
        g.addr = '0;
      end
    end
    return g;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_KEEP_LIMIT:    lim_reserve = 64'(v);
      CFG_STEAL_LIMIT:   lim_steal = 64'(v);
      CFG_CACHE_DISABLE: cache_off = v[0];
      CFG_MIN_KEEP:      keep_lo = int'(v[LOG2_W-1:0]);
      CFG_MAX_KEEP:      keep_hi = int'(v[LOG2_W-1:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_limits(logic [LIMIT_W-1:0] reserve, logic [LIMIT_W-1:0] steal,
                            int lo, int hi);
    cfg_write(CFG_KEEP_LIMIT, reserve);
    cfg_write(CFG_STEAL_LIMIT, steal);
    cfg_write(CFG_MIN_KEEP, LIMIT_W'(lo));
    cfg_write(CFG_MAX_KEEP, LIMIT_W'(hi));
  endtask

  task automatic send_req(logic c, int core, int cls, logic [ADDR_W-1:0] a);
    in_valid <= 1'b1;
    req_cmd <= c;
    req_core <= CORE_W'(core);
    req_log2 <= LOG2_W'(cls);
    req_addr <= a;
    do @(posedge clk); while (!in_ready);
    grant_q.insert(grant_q.size(), predict_grant(c, core, cls, a));
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic run_random(int n, int lo, int hi, int free_pct);
    logic              c;
    int                core;
    int                cls;
    logic [ADDR_W-1:0] a;
    repeat (n) begin
      a = ADDR_W'({$urandom, $urandom});
      core = $urandom_range(0, CORES - 1);
      if ($urandom_range(0, 9) == 0) begin
        c = 1'($urandom_range(0, 1));
        cls = $urandom_range(0, CLASSES - 1);
      end else begin
        c = ($urandom_range(0, 99) < free_pct) ? CMD_FREE : CMD_ALLOC;
        cls = $urandom_range(lo, hi);
      end
      send_req(c, core, cls, a);
    end
  endtask

  task automatic test_keep_bounds();
    gaps_on = 1'b0;
    rx_mode = 0;
    send_req(CMD_FREE, 0, 13, {ADDR_W{1'b1}});
    send_req(CMD_FREE, 0, 13, '0);
    send_req(CMD_FREE, 1, 12, 48'h1234_5678_9abc);
    send_req(CMD_FREE, 2, 26, 48'h8000_0000_0001);
    send_req(CMD_FREE, 3, 25, 48'h5555_aaaa_5555);
    send_req(CMD_FREE, 3, 0, 48'h0000_0000_0040);
    send_req(CMD_FREE, 3, 63, 48'hffff_0000_ffff);
    send_req(CMD_ALLOC, 0, 13, 48'hdead_beef_0000);
    send_req(CMD_ALLOC, 0, 13, '0);
    send_req(CMD_ALLOC, 0, 13, '0);
    send_req(CMD_ALLOC, 1, 63, {ADDR_W{1'b1}});
  endtask

  task automatic test_steal_order();
    cfg_write(CFG_STEAL_LIMIT, '0);
    send_req(CMD_FREE, 1, 20, 48'h0000_0010_0000);
    send_req(CMD_FREE, 3, 20, 48'h0000_0020_0000);
    send_req(CMD_ALLOC, 0, 20, '0);
    send_req(CMD_ALLOC, 2, 20, '0);
    send_req(CMD_FREE, 0, 18, 48'h0000_0004_0000);
    send_req(CMD_ALLOC, 3, 18, '0);
    send_req(CMD_ALLOC, 3, 25, '0);
    send_req(CMD_ALLOC, 1, 18, '0);
  endtask

  task automatic test_cache_disable();
    cfg_write(CFG_CACHE_DISABLE, LIMIT_W'(1));
    send_req(CMD_FREE, 0, 15, 48'h0000_0000_8000);
    send_req(CMD_ALLOC, 2, 15, '0);
    run_random(150, 0, CLASSES - 1, 50);
    cfg_write(CFG_CACHE_DISABLE, '0);
  endtask

  task automatic test_backpressure();
    set_limits(LIMIT_W'(64'd1 << 30), LIMIT_W'(4096), 12, 17);
    gaps_on = 1'b0;
    rx_mode = 0;
    hold_cycles = 200;
    run_random(40, 13, 16, 50);
    drain();
  endtask

  task automatic test_random_defaults();
    set_limits(KEEP_LIMIT_RST, STEAL_LIMIT_RST, int'(MIN_KEEP_RST), int'(MAX_KEEP_RST));
    gaps_on = 1'b1;
    rx_mode = 1;
    run_random(350, 11, 26, 55);
  endtask

  task automatic test_random_wide_limits();
    set_limits(LIMIT_W'(64'd1 << 40), '0, 0, 63);
    rx_mode = 2;
    run_random(350, 0, 44, 55);
  endtask

  task automatic test_random_tight_limits();
    set_limits(LIMIT_W'(100000), LIMIT_W'(30000), 3, 14);
    rx_mode = 3;
    run_random(350, 2, 15, 60);
  endtask

  task automatic test_random_release_all();
    set_limits('0, LIMIT_W'(64'd1 << 40), 12, 26);
    rx_mode = 1;
    run_random(150, 10, 20, 50);
    set_limits(LIMIT_W'(64'd1 << 40), '0, 63, 0);
    run_random(100, 0, 63, 50);
  endtask

  task automatic test_random_small_classes();
    set_limits(LIMIT_W'(64'd1 << 36), LIMIT_W'(64'd1 << 20), 4, 9);
    gaps_on = 1'b0;
    rx_mode = 0;
    run_random(170, 4, 9, 50);
    gaps_on = 1'b1;
    rx_mode = 1;
    run_random(170, 4, 9, 50);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_keep_bounds();
    test_steal_order();
    test_cache_disable();
    test_backpressure();
    test_random_defaults();
    test_random_wide_limits();
    test_random_tight_limits();
    test_random_release_all();
    test_random_small_classes();
    drain();
    if (errors == 0) begin
      $display("per_core_chunk_free_list_cache_tb: PASS");
    end else begin
      $display("per_core_chunk_free_list_cache_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/pcfl_pkg.sv
rtl/pcfl_ram.sv
rtl/per_core_chunk_free_list_cache.sv
dv/per_core_chunk_free_list_cache_tb.sv
